>>> rtl/dual_motor_drive_with_kickstart_top_assert.svh
// Assertion macros used by the drive top level.
`ifndef DUAL_MOTOR_DRIVE_WITH_KICKSTART_TOP_ASSERT_SVH
`define DUAL_MOTOR_DRIVE_WITH_KICKSTART_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define DMDK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmdk: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define DMDK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmdk: next-cycle check failed");

`else

`define DMDK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DMDK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/dmdk_pkg.sv
package dmdk_pkg;

    // Request codes
    typedef enum logic [2:0] {
        REQ_SPEED    = 3'd0,
        REQ_TICK     = 3'd1,
        REQ_LOCK_FWD = 3'd2,
        REQ_LOCK_BWD = 3'd3,
        REQ_LOCK_ALL = 3'd4
    } req_e;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEAD_BAND  = 2'd0,
        REG_KICK_LIMIT = 2'd1,
        REG_KICK_TICKS = 2'd2,
        REG_KICK_PWM   = 2'd3
    } reg_idx_e;

    // Pin codes: bit 1 forward, bit 0 backward
    localparam logic [1:0] PINS_FWD   = 2'b10;
    localparam logic [1:0] PINS_BWD   = 2'b01;
    localparam logic [1:0] PINS_BRAKE = 2'b11;

    localparam logic [6:0] MAG_BRAKE  = 7'd127;
    localparam logic [7:0] BRAKE_DUTY = 8'd254;

    // Register reset values
    localparam logic [6:0] DEAD_BAND_RST  = 7'd10;
    localparam logic [6:0] KICK_LIMIT_RST = 7'd30;
    localparam logic [7:0] KICK_TICKS_RST = 8'd20;
    localparam logic [7:0] KICK_PWM_RST   = 8'hff;

    typedef struct packed {
        req_e              req_type;
        logic signed [7:0] speed_left;
        logic signed [7:0] speed_right;
        logic              lock_value;
        logic              filter_enable;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pwm_left;
        logic [7:0] pwm_right;
        logic       left_forward_pin;
        logic       left_backward_pin;
        logic       right_forward_pin;
        logic       right_backward_pin;
        logic       kick_pending;
    } drv_t;

    // Per-motor state
    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] pins;
        logic [7:0] target;
        logic       kicking;
    } motor_t;

    typedef struct packed {
        logic fwd;
        logic bwd;
        logic all;
    } lock_t;

    // Settings a motor channel needs
    typedef struct packed {
        logic [6:0] dead_band;
        logic [6:0] kick_limit;
        logic [7:0] kick_pwm;
    } motor_cfg_t;

endpackage

>>> rtl/dmdk_motor.sv
// One motor channel: saturate, filter, pick pins and duty, start a kick.
module dmdk_motor (
    input  logic signed [7:0]    speed,
    input  logic                 filter_enable,
    input  dmdk_pkg::lock_t      locks,
    input  dmdk_pkg::motor_cfg_t cfg,
    input  dmdk_pkg::motor_t     cur,
    output dmdk_pkg::motor_t     nxt,
    output logic                 kick_start
);
    import dmdk_pkg::*;

    logic signed [7:0] sat;
    logic              neg;
    logic              pos;
    logic [7:0]        abs_full;
    logic [6:0]        mag;
    logic              zero_f;
    logic              eff_pos;
    logic              eff_neg;
    logic [6:0]        eff_mag;

    // Saturate -128 and take magnitude
    always_comb
    begin
        sat      = (speed == -8'sd128) ? -8'sd127 : speed;
        neg      = sat[7];
        pos      = !neg && (sat != 8'sd0);
        abs_full = neg ? (8'd0 - sat) : sat;
        mag      = abs_full[6:0];
    end

    // Locks and dead band
    always_comb
    begin
        zero_f  = filter_enable &&
                  ((neg && locks.bwd) || (pos && locks.fwd) || locks.all ||
                   (mag < cfg.dead_band));
        eff_pos = pos && !zero_f;
        eff_neg = neg && !zero_f;
        eff_mag = (eff_pos || eff_neg) ? mag : MAG_BRAKE;
    end

    // Pins, duty and kick start
    always_comb
    begin
        nxt = cur;
        if (eff_pos)
        begin
            nxt.pins = PINS_FWD;
        end
        else if (eff_neg)
        begin
            nxt.pins = PINS_BWD;
        end
        else
        begin
            nxt.pins = PINS_BRAKE;
        end
        kick_start = (cur.duty == 8'd0) && (eff_mag != 7'd0) &&
                     (eff_mag < cfg.kick_limit);
        if (kick_start)
        begin
            nxt.duty    = cfg.kick_pwm;
            nxt.target  = {eff_mag, 1'b0};
            nxt.kicking = 1'b1;
        end
        else
        begin
            nxt.duty = {eff_mag, 1'b0};
        end
    end

endmodule

>>> rtl/dual_motor_drive_with_kickstart_top.sv
// Channel  | Handshake              | Payload
// cmd      | cmd_valid / cmd_ready  | cmd (cmd_t): request, speeds, lock value, filter
// drv      | drv_valid / drv_ready  | drv (drv_t): duties, pins, kick pending
// config   | psel/penable/pwrite    | paddr, pwdata, prdata; pready tied high
//
// One command per cycle: the command is decoded and the motor state is updated
// at the accepting edge, and that state register then drives the result.
// A new command is taken in the same cycle the pending result transfers.
// Reset puts both motors in brake (pins high, duty 0), clears kicks and locks,
// and loads the register defaults. No clearing pass.
// A stalled result holds the state, and the command side stalls with it.
`include "dual_motor_drive_with_kickstart_top_assert.svh"

module dual_motor_drive_with_kickstart_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  dmdk_pkg::cmd_t cmd,
    output logic           drv_valid,
    input  logic           drv_ready,
    output dmdk_pkg::drv_t drv
);
    import dmdk_pkg::*;

    logic [6:0] dead_band_reg;
    logic [6:0] kick_limit_reg;
    logic [7:0] kick_ticks_reg;
    logic [7:0] kick_pwm_reg;

    motor_t     ml_reg;
    motor_t     ml_next;
    motor_t     mr_reg;
    motor_t     mr_next;
    lock_t      lock_reg;
    lock_t      lock_next;
    logic [7:0] cd_reg;
    logic [7:0] cd_next;
    logic       out_valid_reg;

    logic       accept;
    logic       cfg_wr;
    reg_idx_e   reg_idx;
    logic       lock_old;
    logic       lock_rise;
    logic       expire;
    logic signed [7:0] spd_l;
    logic signed [7:0] spd_r;
    motor_cfg_t mcfg;
    motor_t     drive_l;
    motor_t     drive_r;
    logic       kick_l;
    logic       kick_r;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_e'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg  <= DEAD_BAND_RST;
            kick_limit_reg <= KICK_LIMIT_RST;
            kick_ticks_reg <= KICK_TICKS_RST;
            kick_pwm_reg   <= KICK_PWM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DEAD_BAND:  dead_band_reg  <= pwdata[6:0];
                REG_KICK_LIMIT: kick_limit_reg <= pwdata[6:0];
                REG_KICK_TICKS: kick_ticks_reg <= pwdata[7:0];
                REG_KICK_PWM:   kick_pwm_reg   <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_DEAD_BAND:  prdata = {25'd0, dead_band_reg};
            REG_KICK_LIMIT: prdata = {25'd0, kick_limit_reg};
            REG_KICK_TICKS: prdata = {24'd0, kick_ticks_reg};
            REG_KICK_PWM:   prdata = {24'd0, kick_pwm_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Handshake: result register frees up as it transfers
    assign cmd_ready = !out_valid_reg || drv_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign drv_valid = out_valid_reg;

    // Lock selection and rising-edge detect
    always_comb
    begin
        unique case (cmd.req_type)
            REQ_LOCK_FWD: lock_old = lock_reg.fwd;
            REQ_LOCK_BWD: lock_old = lock_reg.bwd;
            REQ_LOCK_ALL: lock_old = lock_reg.all;
            default:      lock_old = 1'b1;
        endcase
        lock_rise = !lock_old && cmd.lock_value;
    end

    // Motor channels; a lock rise drives zero speed (brake)
    assign spd_l = (cmd.req_type == REQ_SPEED) ? cmd.speed_left  : 8'sd0;
    assign spd_r = (cmd.req_type == REQ_SPEED) ? cmd.speed_right : 8'sd0;
    assign mcfg  = '{dead_band: dead_band_reg, kick_limit: kick_limit_reg,
                     kick_pwm: kick_pwm_reg};

    dmdk_motor u_motor_l (
        .speed         (spd_l),
        .filter_enable (cmd.filter_enable),
        .locks         (lock_reg),
        .cfg           (mcfg),
        .cur           (ml_reg),
        .nxt           (drive_l),
        .kick_start    (kick_l)
    );

    dmdk_motor u_motor_r (
        .speed         (spd_r),
        .filter_enable (cmd.filter_enable),
        .locks         (lock_reg),
        .cfg           (mcfg),
        .cur           (mr_reg),
        .nxt           (drive_r),
        .kick_start    (kick_r)
    );

    // Next state per request
    assign expire = (cd_reg == 8'd0);

    always_comb
    begin
        ml_next   = ml_reg;
        mr_next   = mr_reg;
        lock_next = lock_reg;
        cd_next   = cd_reg;
        case (cmd.req_type) inside
            REQ_SPEED:
            begin
                ml_next = drive_l;
                mr_next = drive_r;
                if (kick_l || kick_r)
                begin
                    cd_next = kick_ticks_reg;
                end
            end
            REQ_TICK:
            begin
                if (ml_reg.kicking && expire)
                begin
                    ml_next.duty    = ml_reg.target;
                    ml_next.kicking = 1'b0;
                end
                if (mr_reg.kicking && expire)
                begin
                    mr_next.duty    = mr_reg.target;
                    mr_next.kicking = 1'b0;
                end
                if ((ml_next.kicking || mr_next.kicking) && !expire)
                begin
                    cd_next = cd_reg - 8'd1;
                end
            end
            REQ_LOCK_FWD, REQ_LOCK_BWD, REQ_LOCK_ALL:
            begin
                if (cmd.req_type == REQ_LOCK_FWD)
                begin
                    lock_next.fwd = cmd.lock_value;
                end
                if (cmd.req_type == REQ_LOCK_BWD)
                begin
                    lock_next.bwd = cmd.lock_value;
                end
                if (cmd.req_type == REQ_LOCK_ALL)
                begin
                    lock_next.all = cmd.lock_value;
                end
                if (lock_rise)
                begin
                    ml_next = drive_l;
                    mr_next = drive_r;
                end
            end
            default: ;
        endcase
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ml_reg        <= '{duty: 8'd0, pins: PINS_BRAKE, target: 8'd0, kicking: 1'b0};
            mr_reg        <= '{duty: 8'd0, pins: PINS_BRAKE, target: 8'd0, kicking: 1'b0};
            lock_reg      <= '0;
            cd_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ml_reg   <= ml_next;
                mr_reg   <= mr_next;
                lock_reg <= lock_next;
                cd_reg   <= cd_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (drv_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result comes straight from the state register
    always_comb
    begin
        drv.pwm_left           = ml_reg.duty;
        drv.pwm_right          = mr_reg.duty;
        drv.left_forward_pin   = ml_reg.pins[1];
        drv.left_backward_pin  = ml_reg.pins[0];
        drv.right_forward_pin  = mr_reg.pins[1];
        drv.right_backward_pin = mr_reg.pins[0];
        drv.kick_pending       = ml_reg.kicking || mr_reg.kicking;
    end

    // Checks
    `DMDK_ASSERT_NEXT(a_accept_valid, clk, rst_n, accept, out_valid_reg)
    `DMDK_ASSERT_IMPL(a_stall_full, clk, rst_n, !cmd_ready, out_valid_reg)
    `DMDK_ASSERT_NEXT(a_lock_brake, clk, rst_n, accept && lock_rise,
        ml_reg.pins == PINS_BRAKE && mr_reg.pins == PINS_BRAKE &&
        ml_reg.duty == BRAKE_DUTY && mr_reg.duty == BRAKE_DUTY)
    `DMDK_ASSERT_NEXT(a_tick_dec, clk, rst_n,
        accept && cmd.req_type == REQ_TICK && !expire && (ml_reg.kicking || mr_reg.kicking),
        cd_reg == $past(cd_reg) - 8'd1)

endmodule
